### sv/tri_pkg.sv
// Package for the triangle rasteriser: types, constants, action and state codes.
// No dependencies.
package tri_pkg;
  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;
  localparam logic [15:0] FAR_DEPTH  = 16'hffff;
  localparam logic [7:0]  ALPHA_FULL = 8'hff;
  localparam logic [14:0] COUNT_MAX  = 15'h7fff;

  typedef enum logic [1:0] {
    ACT_DRAW  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SETUP2,
    ST_PIX,
    ST_MUL,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_RMW,
    ST_WRITE,
    ST_READ,
    ST_READ2,
    ST_CLEAR,
    ST_INIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic setup2;
    logic pix_eval;
    logic mul;
    logic sum;
    logic div_start;
    logic mem_rd;
    logic mem_wr;
    logic next_pix;
    logic clr_start;
    logic clr_step;
    logic rd_req;
    logic rd_take;
    logic res_zero;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic covered;
    logic div_done;
    logic pass;
    logic last_pix;
    logic clr_done;
  } stat_t;
endpackage

### sv/tri_if.sv
// Valid/ready channel interfaces for requests, results and configuration writes.
// Depends on nothing.
interface tri_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [10:0] first_x;
  logic signed [10:0] first_y;
  logic [15:0]        first_z;
  logic signed [10:0] second_x;
  logic signed [10:0] second_y;
  logic [15:0]        second_z;
  logic signed [10:0] third_x;
  logic signed [10:0] third_y;
  logic [15:0]        third_z;
  logic [23:0]        fill_color;
  modport source (output valid, action, first_x, first_y, first_z, second_x, second_y,
                  second_z, third_x, third_y, third_z, fill_color, input ready);
  modport sink (input valid, action, first_x, first_y, first_z, second_x, second_y,
                second_z, third_x, third_y, third_z, fill_color, output ready);
endinterface

interface tri_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_color;
  logic [15:0] read_depth;
  logic [14:0] pixels_written;
  modport source (output valid, read_color, read_depth, pixels_written, input ready);
  modport sink (input valid, read_color, read_depth, pixels_written, output ready);
endinterface

interface tri_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/tri_ctrl.sv
// Controller state machine of the rasteriser.
// Depends on tri_pkg.
module tri_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic [1:0]     req_action,
  output logic           req_ready,
  output logic           res_valid,
  input  logic           res_ready,
  input  tri_pkg::stat_t stat,
  output tri_pkg::cmd_t  cmd
);
  tri_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= tri_pkg::ST_INIT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    res_valid = 1'b0;
    case (state)
      tri_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          case (tri_pkg::action_t'(req_action))
            tri_pkg::ACT_DRAW:  state_next = tri_pkg::ST_SETUP;
            tri_pkg::ACT_READ:  state_next = tri_pkg::ST_READ;
            tri_pkg::ACT_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next = tri_pkg::ST_CLEAR;
            end
            default: state_next = tri_pkg::ST_RESULT;
          endcase
        end
      end
      tri_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        state_next = tri_pkg::ST_SETUP2;
      end
      tri_pkg::ST_SETUP2: begin
        cmd.setup2 = 1'b1;
        state_next = tri_pkg::ST_PIX;
      end
      tri_pkg::ST_PIX: begin
        if (stat.empty) state_next = tri_pkg::ST_RESULT;
        else begin
          cmd.pix_eval = 1'b1;
          state_next = tri_pkg::ST_MUL;
        end
      end
      tri_pkg::ST_MUL: begin
        if (!stat.covered) begin
          cmd.next_pix = 1'b1;
          state_next = stat.last_pix ? tri_pkg::ST_RESULT : tri_pkg::ST_PIX;
        end else begin
          cmd.mul = 1'b1;
          state_next = tri_pkg::ST_SUM;
        end
      end
      tri_pkg::ST_SUM: begin
        cmd.sum = 1'b1;
        state_next = tri_pkg::ST_START;
      end
      tri_pkg::ST_START: begin
        cmd.div_start = 1'b1;
        state_next = tri_pkg::ST_DIV;
      end
      tri_pkg::ST_DIV: begin
        if (stat.div_done) begin
          cmd.mem_rd = 1'b1;
          state_next = tri_pkg::ST_RMW;
        end
      end
      tri_pkg::ST_RMW: state_next = tri_pkg::ST_WRITE;
      tri_pkg::ST_WRITE: begin
        cmd.mem_wr = stat.pass;
        cmd.next_pix = 1'b1;
        state_next = stat.last_pix ? tri_pkg::ST_RESULT : tri_pkg::ST_PIX;
      end
      tri_pkg::ST_READ: begin
        cmd.rd_req = 1'b1;
        state_next = tri_pkg::ST_READ2;
      end
      tri_pkg::ST_READ2: begin
        cmd.rd_take = 1'b1;
        state_next = tri_pkg::ST_RESULT;
      end
      tri_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = tri_pkg::ST_RESULT;
      end
      tri_pkg::ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = tri_pkg::ST_IDLE;
      end
      tri_pkg::ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) state_next = tri_pkg::ST_IDLE;
      end
      default: state_next = tri_pkg::ST_IDLE;
    endcase
    if (rst) cmd.res_zero = 1'b1;
  end
endmodule

### sv/tri_div.sv
// Radix-2 restoring divider for the depth quotient, one bit a cycle.
// Depends on nothing.
module tri_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [23:0] den,
  output logic        done,
  output logic [47:0] quo
);
  logic [24:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [24:0] trial;

  assign trial = {rem[23:0], quo[47]} - {1'b0, den};
  assign done = !busy && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd47;
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      if (!trial[24]) begin
        rem <= trial;
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= {rem[23:0], quo[47]};
        quo <= {quo[46:0], 1'b0};
      end
      if (cnt == 6'd0) busy <= 1'b0;
      cnt <= cnt - 6'd1;
    end
  end
endmodule

### sv/tri_dp.sv
// Datapath: setup, edge tests, depth blend, divider and frame stores.
// Depends on tri_pkg and tri_div.
module tri_dp #(
  parameter int MAX_WIDTH  = tri_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tri_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tri_pkg::cmd_t      cmd,
  output tri_pkg::stat_t     stat,
  input  logic [1:0]         action,
  input  logic signed [10:0] x1_in, y1_in,
  input  logic [15:0]        z1_in,
  input  logic signed [10:0] x2_in, y2_in,
  input  logic [15:0]        z2_in,
  input  logic signed [10:0] x3_in, y3_in,
  input  logic [15:0]        z3_in,
  input  logic [23:0]        color_in,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  output logic [31:0]        read_color,
  output logic [15:0]        read_depth,
  output logic [14:0]        pixels_written
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(DEPTH);

  logic [15:0] depth_mem [DEPTH];
  logic [31:0] color_mem [DEPTH];

  logic [7:0] frame_width, frame_height;
  logic signed [10:0] x1, y1, x2, y2, x3, y3;
  logic [15:0] z1, z2, z3;
  logic [23:0] color;
  logic signed [11:0] dx12, dx23, dx31, dy12, dy23, dy31;
  logic tl12, tl23, tl31;
  logic signed [23:0] area2;
  logic signed [12:0] xs, xe, ys, ye, px, py;
  logic signed [24:0] e12, e23, e31, n1, n2;
  logic cov;
  logic signed [41:0] p1, p2, p3;
  logic [47:0] num_mag;
  logic neg;
  logic [23:0] den_mag;
  logic div_done;
  logic [47:0] quo;
  logic [15:0] q;
  logic [AW-1:0] addr, clr_addr;
  logic [15:0] old_depth, rd_depth;
  logic [31:0] rd_color;
  logic in_frame;

  function automatic logic signed [12:0] min3(logic signed [12:0] a, b, c);
    logic signed [12:0] m;
    m = a < b ? a : b;
    return m < c ? m : c;
  endfunction
  function automatic logic signed [12:0] max3(logic signed [12:0] a, b, c);
    logic signed [12:0] m;
    m = a > b ? a : b;
    return m > c ? m : c;
  endfunction
  // row-major store index, pixel (x, y) at y * MAX_WIDTH + x
  function automatic logic [AW-1:0] pix_addr(logic signed [12:0] x, y);
    return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  logic signed [12:0] aw, ah;
  assign aw = (frame_width  > 8'(MAX_WIDTH  > 255 ? 255 : MAX_WIDTH)  && MAX_WIDTH  < 256)
            ? 13'(MAX_WIDTH)  : 13'({1'b0, frame_width});
  assign ah = (frame_height > 8'(MAX_HEIGHT > 255 ? 255 : MAX_HEIGHT) && MAX_HEIGHT < 256)
            ? 13'(MAX_HEIGHT) : 13'({1'b0, frame_height});

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 8'd128;
      frame_height <= 8'd128;
    end else if (cfg_we) begin
      if (cfg_index == tri_pkg::CFG_WIDTH) frame_width <= cfg_data;
      else frame_height <= cfg_data;
    end
  end

  assign addr = pix_addr(px, py);
  assign e12 = 25'(dx12) * 25'(py - 13'(y1)) - 25'(dy12) * 25'(px - 13'(x1));
  assign e23 = 25'(dx23) * 25'(py - 13'(y2)) - 25'(dy23) * 25'(px - 13'(x2));
  assign e31 = 25'(dx31) * 25'(py - 13'(y3)) - 25'(dy31) * 25'(px - 13'(x3));
  assign q = (neg || quo == 48'd0) ? 16'd0 : (|quo[47:16] ? 16'hffff : quo[15:0]);
  assign in_frame = !x1[10] && !y1[10] && 13'(x1) < aw && 13'(y1) < ah;

  assign stat.empty = area2 == 24'sd0 || xs >= xe || ys >= ye;
  assign stat.covered = cov;
  assign stat.div_done = div_done;
  assign stat.pass = q < old_depth;
  assign stat.last_pix = px + 13'sd1 >= xe && py + 13'sd1 >= ye;
  assign stat.clr_done = clr_addr == AW'(DEPTH - 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1 <= x1_in; y1 <= y1_in; z1 <= z1_in;
      x2 <= x2_in; y2 <= y2_in; z2 <= z2_in;
      x3 <= x3_in; y3 <= y3_in; z3 <= z3_in;
      color <= color_in;
    end
    if (cmd.setup) begin
      dx12 <= 12'(x1) - 12'(x2); dx23 <= 12'(x2) - 12'(x3); dx31 <= 12'(x3) - 12'(x1);
      dy12 <= 12'(y1) - 12'(y2); dy23 <= 12'(y2) - 12'(y3); dy31 <= 12'(y3) - 12'(y1);
      xs <= max3(min3(13'(x1), 13'(x2), 13'(x3)), 13'sd0, 13'sd0);
      ys <= max3(min3(13'(y1), 13'(y2), 13'(y3)), 13'sd0, 13'sd0);
      xe <= min3(max3(13'(x1), 13'(x2), 13'(x3)), aw, aw);
      ye <= min3(max3(13'(y1), 13'(y2), 13'(y3)), ah, ah);
    end
    if (cmd.setup2) begin
      area2 <= 24'(dy23) * 24'(-dx31) + 24'(-dx23) * 24'(-dy31);
      tl12 <= dy12 < 0 || (dy12 == 0 && dx12 > 0);
      tl23 <= dy23 < 0 || (dy23 == 0 && dx23 > 0);
      tl31 <= dy31 < 0 || (dy31 == 0 && dx31 > 0);
      px <= xs; py <= ys;
      pixels_written <= '0;
    end
    if (cmd.pix_eval) begin
      cov <= (tl12 ? e12 >= 0 : e12 > 0) && (tl23 ? e23 >= 0 : e23 > 0)
          && (tl31 ? e31 >= 0 : e31 > 0);
      n1 <= 25'(dy23) * 25'(px - 13'(x3)) + 25'(-dx23) * 25'(py - 13'(y3));
      n2 <= 25'(dy31) * 25'(px - 13'(x3)) + 25'(-dx31) * 25'(py - 13'(y3));
    end
    if (cmd.mul) begin
      p1 <= 42'(n1) * 42'($signed({1'b0, z1}));
      p2 <= 42'(n2) * 42'($signed({1'b0, z2}));
      p3 <= 42'(25'(area2) - n1 - n2) * 42'($signed({1'b0, z3}));
    end
    if (cmd.sum) begin
      logic signed [43:0] s;
      s = 44'(p1) + 44'(p2) + 44'(p3);
      if (area2 < 0) s = -s;
      neg <= s < 0;
      num_mag <= 48'(s < 0 ? -s : s);
      den_mag <= area2 < 0 ? 24'(-area2) : 24'(area2);
    end
    if (cmd.mem_rd) old_depth <= depth_mem[addr];
    if (cmd.mem_wr) begin
      depth_mem[addr] <= q;
      color_mem[addr] <= {tri_pkg::ALPHA_FULL, color};
      if (pixels_written != tri_pkg::COUNT_MAX) pixels_written <= pixels_written + 15'd1;
    end
    if (cmd.next_pix) begin
      if (px + 13'sd1 >= xe) begin
        px <= xs; py <= py + 13'sd1;
      end else px <= px + 13'sd1;
    end
    if (cmd.clr_start || cmd.res_zero) clr_addr <= '0;
    else if (cmd.clr_step) begin
      depth_mem[clr_addr] <= tri_pkg::FAR_DEPTH;
      color_mem[clr_addr] <= '0;
      clr_addr <= clr_addr + AW'(1);
    end
    if (cmd.rd_req) begin
      rd_depth <= depth_mem[pix_addr(13'(x1), 13'(y1))];
      rd_color <= color_mem[pix_addr(13'(x1), 13'(y1))];
    end
    if (cmd.load) begin
      read_color <= '0; read_depth <= '0;
      if (action != tri_pkg::ACT_DRAW) pixels_written <= '0;
    end
    if (cmd.rd_take && in_frame) begin
      read_color <= rd_color; read_depth <= rd_depth;
    end
  end

  tri_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(num_mag), .den(den_mag),
    .done(div_done), .quo(quo)
  );
endmodule

### sv/triangle_edge_rasterizer_zbuffer.sv
// Top level: triangle rasteriser with depth buffer; ties controller and datapath.
// A draw walks the clamped bounding box, and each covered pixel waits on the 48-step serial
// depth divider; a read fetches one stored pixel, a clear wipes all MAX_WIDTH*MAX_HEIGHT
// entries and an unused action goes straight to the result. One request at a time, the
// next taken in the cycle after the result is accepted. Reset (synchronous) runs a clearing
// pass over the whole store before the first request; frame size resets to 128 x 128.
// Depends on tri_pkg, tri_if, tri_ctrl, tri_dp.
module triangle_edge_rasterizer_zbuffer #(
  parameter int MAX_WIDTH  = tri_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tri_pkg::MAX_HEIGHT_DEF
) (
  input logic clk,
  input logic rst,
  tri_req_if.sink   req,
  tri_res_if.source res,
  tri_cfg_if.sink   cfg
);
  tri_pkg::cmd_t  cmd;
  tri_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  tri_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req.valid), .req_action(req.action),
    .req_ready(req.ready), .res_valid(res.valid), .res_ready(res.ready),
    .stat(stat), .cmd(cmd)
  );

  tri_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .action(req.action),
    .x1_in(req.first_x), .y1_in(req.first_y), .z1_in(req.first_z),
    .x2_in(req.second_x), .y2_in(req.second_y), .z2_in(req.second_z),
    .x3_in(req.third_x), .y3_in(req.third_y), .z3_in(req.third_z),
    .color_in(req.fill_color), .cfg_we(cfg.valid), .cfg_index(cfg.index),
    .cfg_data(cfg.data), .read_color(res.read_color), .read_depth(res.read_depth),
    .pixels_written(res.pixels_written)
  );
endmodule

### verif/tb_triangle_edge_rasterizer_zbuffer.sv
// Testbench for triangle_edge_rasterizer_zbuffer: a queue-fed request driver and a
// result monitor, checked against an in-bench predictor of the frame and depth stores.
// Depends on tri_pkg, tri_if and the rasteriser RTL.
`timescale 1ns / 100ps

module tb_triangle_edge_rasterizer_zbuffer;
  localparam int FW = tri_pkg::MAX_WIDTH_DEF;
  localparam int FH = tri_pkg::MAX_HEIGHT_DEF;
  localparam int QUIET_LIMIT = 200000;

  typedef struct {
    tri_pkg::action_t   act;
    logic signed [10:0] x1, y1, x2, y2, x3, y3;
    logic [15:0]        z1, z2, z3;
    logic [23:0]        rgb;
  } tri_req_t;

  typedef struct {
    logic [31:0] color;
    logic [15:0] depth;
    logic [14:0] count;
  } tri_res_t;

  logic clk;
  logic rst;

  tri_req_if req_ch();
  tri_res_if res_ch();
  tri_cfg_if cfg_ch();

  triangle_edge_rasterizer_zbuffer u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  tri_req_t    pending_reqs[$];
  tri_res_t    expected_res[$];
  tri_req_t    on_bus;
  logic [15:0] depth_mem [FW*FH];
  logic [31:0] color_mem [FW*FH];
  logic [7:0]  frame_w_reg;
  logic [7:0]  frame_h_reg;
  int          errors;
  int          send_gap;
  int          hold_left;
  int          quiet;
  logic        no_idle;
  logic        long_hold_go;
  logic        long_hold_done;

  function automatic longint act_w();
    return (frame_w_reg > FW) ? longint'(FW) : longint'(frame_w_reg);
  endfunction

  function automatic longint act_h();
    return (frame_h_reg > FH) ? longint'(FH) : longint'(frame_h_reg);
  endfunction

  function automatic void wipe_frame();
    for (int i = 0; i < FW*FH; i++) begin
      depth_mem[i] = tri_pkg::FAR_DEPTH;
      color_mem[i] = '0;
    end
  endfunction

  function automatic bit edge_ok(longint e, bit tl);
    return tl ? (e >= 0) : (e > 0);
  endfunction

  function automatic bit top_left(longint dx, longint dy);
    return (dy < 0) || (dy == 0 && dx > 0);
  endfunction

  function automatic logic [14:0] raster_draw(tri_req_t r);
    longint x1, y1, z1, x2, y2, z2, x3, y3, z3;
    longint dx12, dx23, dx31, dy12, dy23, dy31, dx32, dx13, dy13, area2;
    longint xmin, xmax, ymin, ymax, e12, e23, e31, n1, n2, n3, num, den, q;
    bit tl12, tl23, tl31;
    logic [31:0] argb;
    int cnt;
    int idx;
    x1 = longint'(r.x1); y1 = longint'(r.y1); z1 = longint'(r.z1);
    x2 = longint'(r.x2); y2 = longint'(r.y2); z2 = longint'(r.z2);
    x3 = longint'(r.x3); y3 = longint'(r.y3); z3 = longint'(r.z3);
    argb = {tri_pkg::ALPHA_FULL, r.rgb};
    dx12 = x1 - x2; dx23 = x2 - x3; dx31 = x3 - x1;
    dy12 = y1 - y2; dy23 = y2 - y3; dy31 = y3 - y1;
    dx32 = x3 - x2; dx13 = x1 - x3; dy13 = y1 - y3;
    area2 = dy23 * dx13 + dx32 * dy13;
    tl12 = top_left(dx12, dy12);
    tl23 = top_left(dx23, dy23);
    tl31 = top_left(dx31, dy31);
    xmin = x1; if (x2 < xmin) xmin = x2; if (x3 < xmin) xmin = x3;
    xmax = x1; if (x2 > xmax) xmax = x2; if (x3 > xmax) xmax = x3;
    ymin = y1; if (y2 < ymin) ymin = y2; if (y3 < ymin) ymin = y3;
    ymax = y1; if (y2 > ymax) ymax = y2; if (y3 > ymax) ymax = y3;
    cnt = 0;
    if (area2 == 0) return '0;
    if (xmin < 0) xmin = 0;
    if (ymin < 0) ymin = 0;
    if (xmax > act_w()) xmax = act_w();
    if (ymax > act_h()) ymax = act_h();
    for (longint y = ymin; y < ymax; y++) begin
      for (longint x = xmin; x < xmax; x++) begin
        e12 = dx12 * (y - y1) - dy12 * (x - x1);
        e23 = dx23 * (y - y2) - dy23 * (x - x2);
        e31 = dx31 * (y - y3) - dy31 * (x - x3);
        if (edge_ok(e12, tl12) && edge_ok(e23, tl23) && edge_ok(e31, tl31)) begin
          n1 = dy23 * (x - x3) + dx32 * (y - y3);
          n2 = dy31 * (x - x3) + dx13 * (y - y3);
          n3 = area2 - n1 - n2;
          num = n1 * z1 + n2 * z2 + n3 * z3;
          den = area2;
          if (den < 0) begin
            den = -den;
            num = -num;
          end
          q = num / den;
          if (q < 0) q = 0;
          if (q > 65535) q = 65535;
          idx = int'(y * FW + x);
          if (q < longint'(depth_mem[idx])) begin
            depth_mem[idx] = q[15:0];
            color_mem[idx] = argb;
            if (cnt < int'(tri_pkg::COUNT_MAX)) cnt++;
          end
        end
      end
    end
    return cnt[14:0];
  endfunction

  function automatic tri_res_t predict_result(tri_req_t r);
    tri_res_t o;
    longint x, y;
    int idx;
    o = '{color: '0, depth: '0, count: '0};
    x = longint'(r.x1);
    y = longint'(r.y1);
    case (r.act)
      tri_pkg::ACT_DRAW: o.count = raster_draw(r);
      tri_pkg::ACT_READ: begin
        if (x >= 0 && y >= 0 && x < act_w() && y < act_h()) begin
          idx = int'(y * FW + x);
          o.color = color_mem[idx];
          o.depth = depth_mem[idx];
        end
      end
      tri_pkg::ACT_CLEAR: wipe_frame();
      default: ;
    endcase
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) expected_res.push_back(predict_result(on_bus));
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          on_bus = pending_reqs.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.action     <= on_bus.act;
          req_ch.first_x    <= on_bus.x1;
          req_ch.first_y    <= on_bus.y1;
          req_ch.first_z    <= on_bus.z1;
          req_ch.second_x   <= on_bus.x2;
          req_ch.second_y   <= on_bus.y2;
          req_ch.second_z   <= on_bus.z2;
          req_ch.third_x    <= on_bus.x3;
          req_ch.third_y    <= on_bus.y3;
          req_ch.third_z    <= on_bus.z3;
          req_ch.fill_color <= on_bus.rgb;
          send_gap = pick_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    tri_res_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_res.size() == 0) begin
          $display("%0t: result with nothing expected: color %h depth %h count %0d", $time,
                   res_ch.read_color, res_ch.read_depth, res_ch.pixels_written);
          errors++;
        end else begin
          want = expected_res.pop_front();
          if (res_ch.read_color !== want.color) begin
            $display("%0t: read_color exp %h got %h", $time, want.color, res_ch.read_color);
            errors++;
          end
          if (res_ch.read_depth !== want.depth) begin
            $display("%0t: read_depth exp %h got %h", $time, want.depth, res_ch.read_depth);
            errors++;
          end
          if (res_ch.pixels_written !== want.count) begin
            $display("%0t: pixels_written exp %0d got %0d", $time, want.count,
                     res_ch.pixels_written);
            errors++;
          end
        end
      end
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = 20000;
      end else if (hold_left == 0 && !no_idle && $urandom_range(0, 199) == 0) begin
        hold_left = $urandom_range(20, 80);
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= no_idle ? 1'b1 : ($urandom_range(0, 9) < 7);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_triangle_edge_rasterizer_zbuffer: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic tri_req_t mk_draw(int ax, int ay, int az, int bx, int by, int bz,
                                       int cx, int cy, int cz, int rgb);
    tri_req_t r;
    r.act = tri_pkg::ACT_DRAW;
    r.x1 = 11'(ax); r.y1 = 11'(ay); r.z1 = 16'(az);
    r.x2 = 11'(bx); r.y2 = 11'(by); r.z2 = 16'(bz);
    r.x3 = 11'(cx); r.y3 = 11'(cy); r.z3 = 16'(cz);
    r.rgb = 24'(rgb);
    return r;
  endfunction

  function automatic tri_req_t mk_noise(tri_pkg::action_t a);
    tri_req_t r;
    r.act = a;
    r.x1 = 11'($urandom); r.y1 = 11'($urandom); r.z1 = 16'($urandom);
    r.x2 = 11'($urandom); r.y2 = 11'($urandom); r.z2 = 16'($urandom);
    r.x3 = 11'($urandom); r.y3 = 11'($urandom); r.z3 = 16'($urandom);
    r.rgb = 24'($urandom);
    return r;
  endfunction

  function automatic tri_req_t mk_read(int x, int y);
    tri_req_t r;
    r = mk_noise(tri_pkg::ACT_READ);
    r.x1 = 11'(x);
    r.y1 = 11'(y);
    return r;
  endfunction

  function automatic void both_windings(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz, int rgb);
    pending_reqs.push_back(mk_draw(ax, ay, az, bx, by, bz, cx, cy, cz, rgb));
    pending_reqs.push_back(mk_draw(ax, ay, az, cx, cy, cz, bx, by, bz, rgb));
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || expected_res.size() != 0 || req_ch.valid);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk);
    while (!cfg_ch.ready);
    if (idx == tri_pkg::CFG_WIDTH) frame_w_reg = val;
    else frame_h_reg = val;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_frame(logic [7:0] w, logic [7:0] h);
    wait_idle();
    cfg_write(tri_pkg::CFG_WIDTH, w);
    cfg_write(tri_pkg::CFG_HEIGHT, h);
  endtask

  // random traffic sized to the active frame; reads lean towards the last draw
  function automatic void fill_random(int n);
    int aw, ah, cx, cy, s, k;
    aw = int'(act_w());
    ah = int'(act_h());
    cx = 0;
    cy = 0;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50) begin
        if (aw * ah <= 256 && $urandom_range(0, 4) == 0) begin
          pending_reqs.push_back(mk_noise(tri_pkg::ACT_DRAW));
        end else begin
          s = $urandom_range(1, 8);
          cx = $urandom_range(0, aw + 7) - 4;
          cy = $urandom_range(0, ah + 7) - 4;
          pending_reqs.push_back(mk_draw(
            cx + $urandom_range(0, 2*s) - s, cy + $urandom_range(0, 2*s) - s, $urandom,
            cx + $urandom_range(0, 2*s) - s, cy + $urandom_range(0, 2*s) - s, $urandom,
            cx + $urandom_range(0, 2*s) - s, cy + $urandom_range(0, 2*s) - s, $urandom,
            $urandom));
        end
      end else if (k < 85) begin
        pending_reqs.push_back(mk_read(cx + $urandom_range(0, 8) - 4,
                                       cy + $urandom_range(0, 8) - 4));
      end else if (k < 92) begin
        pending_reqs.push_back(mk_noise(tri_pkg::ACT_READ));
      end else if (k < 97) begin
        pending_reqs.push_back(mk_noise(tri_pkg::ACT_NONE));
      end else begin
        pending_reqs.push_back(mk_noise(tri_pkg::ACT_CLEAR));
      end
    end
  endfunction

  initial begin
    logic [7:0] fw [8] = '{8'd128, 8'd255, 8'd8, 8'd1, 8'd0, 8'd37, 8'd128, 8'd200};
    logic [7:0] fh [8] = '{8'd128, 8'd255, 8'd8, 8'd1, 8'd5, 8'd90, 8'd1, 8'd17};
    errors = 0;
    no_idle = 1'b0;
    long_hold_go = 1'b0;
    frame_w_reg = 8'd128;
    frame_h_reg = 8'd128;
    wipe_frame();
    req_ch.valid = 1'b0;
    req_ch.action = tri_pkg::ACT_NONE;
    req_ch.first_x = '0; req_ch.first_y = '0; req_ch.first_z = '0;
    req_ch.second_x = '0; req_ch.second_y = '0; req_ch.second_z = '0;
    req_ch.third_x = '0; req_ch.third_y = '0; req_ch.third_z = '0;
    req_ch.fill_color = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = tri_pkg::CFG_WIDTH;
    cfg_ch.data = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed, reset frame size
    pending_reqs.push_back(mk_read(0, 0));
    both_windings(2, 2, 0, 10, 2, 65535, 2, 10, 30000, 24'hffffff);
    pending_reqs.push_back(mk_draw(1, 1, 5, 5, 5, 5, 9, 9, 5, 24'h123456));
    both_windings(20, 20, 100, 30, 20, 200, 20, 30, 300, 24'h00ff00);
    both_windings(30, 20, 100, 30, 30, 200, 20, 30, 300, 24'h0000ff);
    both_windings(120, 120, 10, 140, 125, 20, 125, 140, 30, 24'hff0000);
    both_windings(-5, -5, 7, 4, -3, 7, -2, 6, 7, 24'h000000);
    both_windings(-5, -5, 7, 4, -3, 7, -2, 6, 7, 24'h808080);
    pending_reqs.push_back(mk_read(3, 3));
    pending_reqs.push_back(mk_read(25, 25));
    pending_reqs.push_back(mk_read(127, 127));
    pending_reqs.push_back(mk_read(128, 0));
    pending_reqs.push_back(mk_read(-1, 5));
    pending_reqs.push_back(mk_read(-1024, 1023));
    pending_reqs.push_back(mk_noise(tri_pkg::ACT_NONE));
    pending_reqs.push_back(mk_noise(tri_pkg::ACT_CLEAR));
    pending_reqs.push_back(mk_read(3, 3));

    // extreme vertices on a small frame
    set_frame(8'd8, 8'd8);
    both_windings(-1024, -1024, 65535, 1023, -1024, 0, -1024, 1023, 65535, 24'hffffff);
    pending_reqs.push_back(mk_read(7, 7));
    pending_reqs.push_back(mk_read(0, 0));
    set_frame(8'd0, 8'd5);
    both_windings(0, 0, 1, 6, 0, 1, 0, 6, 1, 24'h00aa55);
    pending_reqs.push_back(mk_read(0, 0));

    for (int p = 0; p < 8; p++) begin
      set_frame(fw[p], fh[p]);
      no_idle = (p == 3);
      if (p == 1) long_hold_go <= 1'b1;
      fill_random(7);
      if (p == 5) wait_idle();
      fill_random(7);
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("tb_triangle_edge_rasterizer_zbuffer: done, clean");
    end else begin
      $display("tb_triangle_edge_rasterizer_zbuffer: done, errors");
    end
    $finish;
  end
endmodule
